[rtl/core/pld_pkg.sv]
package pld_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int TIMER_BITS  = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 1;

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_CHECK  = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam logic [1:0] ST_NA        = 2'd0;
  localparam logic [1:0] ST_DETECTED  = 2'd1;
  localparam logic [1:0] ST_TOO_QUIET = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_DECAY_STEP    = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_QUIET_TIMEOUT = 1'd1;

  // 0.005 of full scale on the Q1.15 scale rounds to 164.
  localparam logic [SAMPLE_BITS-1:0] DECAY_STEP_RESET    = SAMPLE_BITS'(164);
  localparam logic [TIMER_BITS-1:0]  QUIET_TIMEOUT_RESET = TIMER_BITS'(40);

  typedef struct packed {
    logic [1:0]                    opcode;
    logic signed [SAMPLE_BITS-1:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]             quiet_status;
    logic [SAMPLE_BITS-1:0] peak_level;
    logic                   status_changed;
  } out_item_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] decay_step;
    logic [TIMER_BITS-1:0]  quiet_timeout;
  } cfg_t;

endpackage

[rtl/core/pld_cfg_regs.sv]
module pld_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pld_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [pld_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output pld_pkg::cfg_t                      cfg
);
  import pld_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_DECAY_STEP:    cfg_nxt.decay_step    = SAMPLE_BITS'(cfg_wdata);
        CFG_QUIET_TIMEOUT: cfg_nxt.quiet_timeout = TIMER_BITS'(cfg_wdata);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.decay_step    <= DECAY_STEP_RESET;
      cfg_r.quiet_timeout <= QUIET_TIMEOUT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[rtl/core/pld_meter.sv]
module pld_meter (
  input  logic                clk,
  input  logic                rst_n,
  input  pld_pkg::cfg_t       cfg,
  input  logic                item_valid,
  input  pld_pkg::in_item_t   item,
  output logic                res_valid,
  output pld_pkg::out_item_t  res
);
  import pld_pkg::*;

  logic [SAMPLE_BITS-1:0] held_level_r, held_level_nxt;
  logic [1:0]             announced_r, announced_nxt;
  logic                   timer_running_r, timer_running_nxt;
  logic [TIMER_BITS-1:0]  quiet_elapsed_r, quiet_elapsed_nxt;

  logic [SAMPLE_BITS-1:0] magnitude;
  logic [SAMPLE_BITS-1:0] faded;
  logic                   zero;
  logic [1:0]             status;

  // Two's complement negate; the most negative sample maps to full scale.
  assign magnitude = item.sample_value[SAMPLE_BITS-1] ?
                     (~item.sample_value) + SAMPLE_BITS'(1) : item.sample_value;

  assign faded = (held_level_r > cfg.decay_step) ? held_level_r - cfg.decay_step : '0;
  assign zero  = (faded == '0);

  always_comb begin
    held_level_nxt    = held_level_r;
    announced_nxt     = announced_r;
    timer_running_nxt = timer_running_r;
    quiet_elapsed_nxt = quiet_elapsed_r;
    status            = ST_DETECTED;
    res_valid         = 1'b0;
    if (item_valid) begin
      case (item.opcode)
        OP_SAMPLE: begin
          if (magnitude > held_level_r) begin
            held_level_nxt = magnitude;
          end
        end
        OP_TICK: begin
          if (timer_running_r && quiet_elapsed_r != '1) begin
            quiet_elapsed_nxt = quiet_elapsed_r + TIMER_BITS'(1);
          end
        end
        OP_CHECK: begin
          res_valid      = 1'b1;
          held_level_nxt = faded;
          if (announced_r == ST_TOO_QUIET) begin
            if (!zero) begin
              timer_running_nxt = 1'b0;
              quiet_elapsed_nxt = '0;
              status            = ST_DETECTED;
            end else begin
              status = ST_TOO_QUIET;
            end
          end else if (zero) begin
            // A fresh start counts from zero before the expiry compare.
            if (!timer_running_r) begin
              timer_running_nxt = 1'b1;
              quiet_elapsed_nxt = '0;
            end
            status = (quiet_elapsed_nxt >= cfg.quiet_timeout) ? ST_TOO_QUIET : ST_DETECTED;
          end else begin
            timer_running_nxt = 1'b0;
            quiet_elapsed_nxt = '0;
            status            = ST_DETECTED;
          end
          announced_nxt = status;
        end
        default: ;
      endcase
    end
  end

  assign res.quiet_status   = status;
  assign res.peak_level     = faded;
  assign res.status_changed = (status != announced_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_level_r    <= '0;
      announced_r     <= ST_NA;
      timer_running_r <= 1'b0;
      quiet_elapsed_r <= '0;
    end else begin
      held_level_r    <= held_level_nxt;
      announced_r     <= announced_nxt;
      timer_running_r <= timer_running_nxt;
      quiet_elapsed_r <= quiet_elapsed_nxt;
    end
  end

  a_idle_timer_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !timer_running_r |-> quiet_elapsed_r == '0)
    else $error("quiet timer idle with a nonzero count");

  a_too_quiet_timer: assert property (@(posedge clk) disable iff (!rst_n)
    announced_r == ST_TOO_QUIET |-> timer_running_r)
    else $error("too quiet announced without a running timer");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    held_level_r <= (SAMPLE_BITS'(1) << (SAMPLE_BITS - 1)))
    else $error("held level above full scale");

endmodule

[rtl/core/peak_level_silence_detector.sv]
// A check request is held in the input register and its result is loaded into the output register.
// Throughput: one request per cycle while no check waits on a full output register; an input
// register feeds the level and timer update, which loads the output register in the same cycle.
// Samples and ticks drain even while a result waits; only a check waits for the
// output register. Synchronous active-low reset clears the level, status and timer
// and loads decay step 164 and quiet timeout 40.
module peak_level_silence_detector (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  pld_pkg::in_item_t                in_item,
  output logic                             out_valid,
  input  logic                             out_ready,
  output pld_pkg::out_item_t               out_item,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pld_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [pld_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import pld_pkg::*;

  cfg_t      cfg;
  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  logic      fire;
  logic      res_valid;
  out_item_t res;

  pld_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign fire = s1_valid_r &&
                (s1_item_r.opcode != OP_CHECK || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || fire;

  pld_meter u_meter (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (fire),
    .item       (s1_item_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

[test/tb_peak_level_silence_detector.sv]
`timescale 1ns / 1ps

module tb_peak_level_silence_detector;
  import pld_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned NO_ACCEPT_LIMIT = 5000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned PHASE_REQUESTS = 240;

  class level_scoreboard;
    logic [SAMPLE_BITS-1:0] fade_step;
    logic [TIMER_BITS-1:0]  silence_limit;
    logic [SAMPLE_BITS-1:0] level;
    logic [1:0]             last_status;
    bit                     timer_on;
    logic [TIMER_BITS-1:0]  silent_ticks;
    out_item_t              expected_reports[$];
    int unsigned            errors;
    int unsigned            reports_checked;
    int unsigned            quiet_reports;
    int unsigned            register_writes;
    int unsigned            requests[4];

    function new();
      fade_step = DECAY_STEP_RESET;
      silence_limit = QUIET_TIMEOUT_RESET;
      level = '0;
      last_status = ST_NA;
      timer_on = 1'b0;
      silent_ticks = '0;
      errors = 0;
      reports_checked = 0;
      quiet_reports = 0;
      register_writes = 0;
      foreach (requests[i]) requests[i] = 0;
    endfunction

    function void set_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      register_writes++;
      if (index == CFG_DECAY_STEP) begin
        fade_step = data;
      end else if (index == CFG_QUIET_TIMEOUT) begin
        silence_limit = data;
      end
    endfunction

    function void note_request(in_item_t req);
      logic [SAMPLE_BITS:0] mag;
      logic [1:0]           status;
      out_item_t            rpt;
      requests[req.opcode]++;
      case (req.opcode)
        OP_SAMPLE: begin
          mag = {1'b0, req.sample_value};
          if (req.sample_value[SAMPLE_BITS-1]) begin
            mag = (SAMPLE_BITS+1)'(1 << SAMPLE_BITS) - mag;
          end
          if (mag > {1'b0, level}) begin
            level = mag[SAMPLE_BITS-1:0];
          end
        end
        OP_TICK: begin
          if (timer_on && silent_ticks != '1) begin
            silent_ticks = silent_ticks + 1'b1;
          end
        end
        OP_CHECK: begin
          level = (level > fade_step) ? level - fade_step : '0;
          if (last_status == ST_TOO_QUIET) begin
            // Once too quiet, only a nonzero level brings the status back.
            if (level != '0) begin
              timer_on = 1'b0;
              silent_ticks = '0;
              status = ST_DETECTED;
            end else begin
              status = ST_TOO_QUIET;
            end
          end else if (level == '0) begin
            if (!timer_on) begin
              timer_on = 1'b1;
              silent_ticks = '0;
            end
            status = (silent_ticks >= silence_limit) ? ST_TOO_QUIET : ST_DETECTED;
          end else begin
            timer_on = 1'b0;
            silent_ticks = '0;
            status = ST_DETECTED;
          end
          rpt.quiet_status = status;
          rpt.peak_level = level;
          rpt.status_changed = (status != last_status);
          expected_reports.push_back(rpt);
          last_status = status;
        end
        default: begin
        end
      endcase
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      errors++;
    endtask

    task check_report(out_item_t got);
      out_item_t want;
      if (expected_reports.size() == 0) begin
        report_mismatch($sformatf("status report with nothing expected: status %0d level %0d",
                                  got.quiet_status, got.peak_level));
        return;
      end
      want = expected_reports.pop_front();
      reports_checked++;
      if (want.quiet_status == ST_TOO_QUIET) quiet_reports++;
      if (got.quiet_status !== want.quiet_status) begin
        report_mismatch($sformatf("quiet_status %0d, expected %0d",
                                  got.quiet_status, want.quiet_status));
      end
      if (got.peak_level !== want.peak_level) begin
        report_mismatch($sformatf("peak_level %0d, expected %0d",
                                  got.peak_level, want.peak_level));
      end
      if (got.status_changed !== want.status_changed) begin
        report_mismatch($sformatf("status_changed %0b, expected %0b",
                                  got.status_changed, want.status_changed));
      end
    endtask
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  in_item_t               in_item;
  logic                   out_valid;
  logic                   out_ready;
  out_item_t              out_item;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  level_scoreboard sb = new();

  int unsigned send_idle_pct = 10;
  int unsigned recv_idle_pct = 57;
  int unsigned phase_requests = 0;
  int unsigned stalled_cycles = 0;
  bit          hold_off_requested = 1'b0;

  peak_level_silence_detector i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result side: random stalls, plus a long hold-off when the stimulus asks for one.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_requested) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_requested = 1'b0;
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_report(out_item);
      if (in_valid && in_ready) sb.note_request(in_item);
      if ((out_valid && out_ready) || (in_valid && in_ready) || (cfg_valid && cfg_ready)) begin
        stalled_cycles <= 0;
      end else if (stalled_cycles + 1 >= NO_ACCEPT_LIMIT) begin
        $display("peak_level_silence_detector regression: fail");
        $finish;
      end else begin
        stalled_cycles <= stalled_cycles + 1;
      end
    end
  end

  function automatic logic [SAMPLE_BITS-1:0] sample_of(int unsigned mag, bit neg);
    int v;
    v = neg ? -int'(mag) : int'(mag);
    return SAMPLE_BITS'(v);
  endfunction

  task automatic send_request(logic [1:0] op, logic [SAMPLE_BITS-1:0] value);
    in_item_t req;
    req.opcode = op;
    req.sample_value = value;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op != OP_UNUSED) phase_requests++;
  endtask

  task automatic write_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_register(index, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Samples and ticks leave no report behind, so let the pipeline settle after the last
  // report before anything touches the registers.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_episode(int unsigned decay, int unsigned timeout);
    int unsigned kind;
    int unsigned span;
    int unsigned quiet_mag;
    int unsigned loud_mag;
    kind = $urandom_range(0, 9);
    span = (timeout < 60) ? timeout + 3 : 24;
    quiet_mag = (decay > 16383) ? 32767 : 2 * decay;
    loud_mag = (decay > 4095) ? 32767 : 8 * decay + 1;
    if (kind < 3) begin
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 3) == 0) begin
          send_request(OP_SAMPLE, SAMPLE_BITS'($urandom));
        end else begin
          send_request(OP_SAMPLE, sample_of($urandom_range(1, loud_mag), $urandom_range(0, 1) == 1));
        end
      end
      repeat ($urandom_range(1, 3)) begin
        send_request(OP_CHECK, SAMPLE_BITS'($urandom));
        if ($urandom_range(0, 1) == 1) send_request(OP_TICK, SAMPLE_BITS'($urandom));
      end
    end else if (kind < 8) begin
      // Small samples fade out, then runs of ticks walk the timer toward the timeout; below 60 they can pass it.
      repeat ($urandom_range(0, 2)) begin
        send_request(OP_SAMPLE, sample_of($urandom_range(0, quiet_mag), $urandom_range(0, 1) == 1));
      end
      repeat ($urandom_range(1, 3)) send_request(OP_CHECK, SAMPLE_BITS'($urandom));
      repeat ($urandom_range(1, 3)) begin
        repeat ($urandom_range(0, span)) send_request(OP_TICK, SAMPLE_BITS'($urandom));
        send_request(OP_CHECK, SAMPLE_BITS'($urandom));
      end
    end else begin
      repeat ($urandom_range(1, 6)) begin
        send_request(2'($urandom_range(0, 3)), SAMPLE_BITS'($urandom));
      end
    end
  endtask

  task automatic run_phase(logic [CFG_DATA_W-1:0] decay, logic [CFG_DATA_W-1:0] timeout,
                           bit with_hold_off);
    wait_drained();
    write_register(CFG_DECAY_STEP, decay);
    write_register(CFG_QUIET_TIMEOUT, timeout);
    if (with_hold_off) begin
      // Checks back up behind the stalled result port until the input stalls too.
      hold_off_requested = 1'b1;
      repeat (24) send_request(OP_CHECK, SAMPLE_BITS'($urandom));
      wait_drained();
    end
    phase_requests = 0;
    while (phase_requests < PHASE_REQUESTS) run_episode(decay, timeout);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: full-scale samples, a smaller one that must not lower the
    // held peak, an unused opcode and a tick while the timer is idle.
    send_request(OP_CHECK, '0);
    send_request(OP_SAMPLE, sample_of(32768, 1'b1));
    send_request(OP_SAMPLE, sample_of(32767, 1'b0));
    send_request(OP_SAMPLE, sample_of(1, 1'b1));
    send_request(OP_CHECK, '1);
    send_request(OP_UNUSED, sample_of(32767, 1'b0));
    send_request(OP_TICK, '0);
    send_request(OP_CHECK, '0);

    // Full-scale fade empties the level at once; the timer then runs into too quiet.
    wait_drained();
    write_register(CFG_DECAY_STEP, CFG_DATA_W'(32768));
    write_register(CFG_QUIET_TIMEOUT, CFG_DATA_W'(2));
    send_request(OP_CHECK, '0);
    send_request(OP_TICK, '0);
    send_request(OP_CHECK, '0);
    send_request(OP_TICK, '0);
    send_request(OP_CHECK, '0);
    send_request(OP_TICK, '0);
    send_request(OP_CHECK, '0);
    send_request(OP_SAMPLE, sample_of(1, 1'b0));
    send_request(OP_CHECK, '0);

    // With no fade a nonzero level leaves too quiet.
    wait_drained();
    write_register(CFG_DECAY_STEP, '0);
    send_request(OP_SAMPLE, sample_of(1, 1'b0));
    send_request(OP_CHECK, '0);
    send_request(OP_CHECK, '0);
    send_request(OP_TICK, '0);

    run_phase(DECAY_STEP_RESET, QUIET_TIMEOUT_RESET, 1'b0);
    run_phase(CFG_DATA_W'(32768), CFG_DATA_W'(1), 1'b0);
    send_idle_pct = 57;
    recv_idle_pct = 10;
    run_phase(CFG_DATA_W'($urandom_range(100, 3000)), '1, 1'b0);
    run_phase(CFG_DATA_W'(1), CFG_DATA_W'($urandom_range(2, 30)), 1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(CFG_DATA_W'($urandom_range(1, 2000)), CFG_DATA_W'($urandom_range(2, 12)), 1'b1);
    run_phase('0, CFG_DATA_W'(5), 1'b0);

    // Silence at the largest timeout: the tick count climbs without reaching too quiet.
    wait_drained();
    write_register(CFG_DECAY_STEP, CFG_DATA_W'(32768));
    send_request(OP_CHECK, '0);
    wait_drained();
    write_register(CFG_DECAY_STEP, CFG_DATA_W'(1));
    write_register(CFG_QUIET_TIMEOUT, '1);
    send_request(OP_SAMPLE, sample_of(2, 1'b0));
    send_request(OP_CHECK, '0);
    send_request(OP_CHECK, '0);
    repeat (64) send_request(OP_TICK, SAMPLE_BITS'($urandom));
    send_request(OP_CHECK, '0);
    send_request(OP_TICK, '0);
    send_request(OP_CHECK, '0);

    wait_drained();
    $display("Run covered %0d samples, %0d checks, %0d ticks and %0d unused opcodes",
             sb.requests[OP_SAMPLE], sb.requests[OP_CHECK], sb.requests[OP_TICK],
             sb.requests[OP_UNUSED]);
    $display("over %0d register writes, compared %0d status reports (%0d too quiet).",
             sb.register_writes, sb.reports_checked, sb.quiet_reports);
    if (sb.errors == 0) begin
      $display("peak_level_silence_detector regression: pass");
    end else begin
      $display("peak_level_silence_detector regression: fail");
    end
    $finish;
  end

endmodule
